/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising clock, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// concurrent assertion that is also checked while reset is held
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) \
	else $error(msg);

`endif

/* sv/b64e_pkg.sv */
// types, constants and the character map of the base64 stream encoder
package b64e_pkg;

	localparam int unsigned B64E_GRP_DEPTH = 2;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	// bytes carried by a group
	localparam logic [1:0] HELD_ONE   = 2'd1;
	localparam logic [1:0] HELD_TWO   = 2'd2;
	localparam logic [1:0] HELD_THREE = 2'd3;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] held;
		logic       eom;
	} grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} grp_stat_t;

	function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
		logic [7:0] ext;
		ext = {2'b00, idx};
		if (idx <= 6'd25) begin
			b64_symbol = ext + 8'd65;
		end else if (idx <= 6'd51) begin
			b64_symbol = ext + 8'd71;
		end else if (idx <= 6'd61) begin
			b64_symbol = ext - 8'd4;
		end else if (idx == 6'd62) begin
			b64_symbol = CH_PLUS;
		end else begin
			b64_symbol = CH_SLASH;
		end
	endfunction

endpackage

/* sv/b64e_front.sv */
// front end: gathers bytes and closes groups of up to three bytes
module b64e_front import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  grp_stat_t  grp_stat,
	output logic       grp_push,
	output grp_t       grp_wdata
);

	localparam logic [1:0] PHASE_EMPTY = 2'd0;
	localparam logic [1:0] PHASE_ONE   = 2'd1;
	localparam logic [1:0] PHASE_TWO   = 2'd2;
	localparam logic [1:0] PHASE_BAD   = 2'd3;

	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] phase_q;
	logic [1:0] phase_eff;
	logic       accept;
	logic       closes;

	assign phase_eff = (phase_q == PHASE_BAD) ? PHASE_EMPTY : phase_q;
	assign full      = grp_stat.full;
	assign accept    = push && !full;
	assign closes    = end_of_message || (phase_eff == PHASE_TWO);
	assign grp_push  = accept && closes;

	// missing bytes of a partial group count as zero
	always_comb begin
		grp_wdata.eom = end_of_message;
		case (phase_eff)
			PHASE_EMPTY: begin
				grp_wdata.b0   = data_byte;
				grp_wdata.b1   = 8'd0;
				grp_wdata.b2   = 8'd0;
				grp_wdata.held = HELD_ONE;
			end
			PHASE_ONE: begin
				grp_wdata.b0   = pend0_q;
				grp_wdata.b1   = data_byte;
				grp_wdata.b2   = 8'd0;
				grp_wdata.held = HELD_TWO;
			end
			default: begin
				grp_wdata.b0   = pend0_q;
				grp_wdata.b1   = pend1_q;
				grp_wdata.b2   = data_byte;
				grp_wdata.held = HELD_THREE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_EMPTY;
		end else if (accept) begin
			if (closes) begin
				phase_q <= PHASE_EMPTY;
			end else begin
				phase_q <= phase_eff + PHASE_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !closes) begin
			if (phase_eff == PHASE_EMPTY) begin
				pend0_q <= data_byte;
			end else begin
				pend1_q <= data_byte;
			end
		end
	end

endmodule

/* sv/b64e_queue.sv */
// short group queue between the front and back ends
module b64e_queue import b64e_pkg::*; #(
	parameter int unsigned DEPTH = B64E_GRP_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  grp_t      wdata,
	input  logic      pop,
	output grp_t      rdata,
	output grp_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	grp_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* sv/b64e_back.sv */
// back end: turns one group into four characters, one per cycle while the output is taken
module b64e_back import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  grp_stat_t  grp_stat,
	input  grp_t       grp_rdata,
	output logic       grp_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] encoded_char,
	output logic       final_char
);

	localparam logic [1:0] SLOT_LAST = 2'd3;

	grp_t       grp_q;
	logic       busy_q;
	logic [1:0] slot_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       fin_q;
	logic       out_ready;
	logic       emit;
	logic [5:0] sextet;
	logic       pad;
	logic [7:0] next_char;

	assign out_ready = !out_valid_q || pop;
	assign emit      = busy_q && out_ready;
	// next group is taken as the last character of the current one leaves
	assign grp_pop   = !grp_stat.empty && (!busy_q || (emit && slot_q == SLOT_LAST));

	always_comb begin
		pad = 1'b0;
		case (slot_q)
			2'd0: sextet = grp_q.b0[7:2];
			2'd1: sextet = {grp_q.b0[1:0], grp_q.b1[7:4]};
			2'd2: begin
				sextet = {grp_q.b1[3:0], grp_q.b2[7:6]};
				pad    = (grp_q.held == HELD_ONE);
			end
			default: begin
				sextet = grp_q.b2[5:0];
				pad    = (grp_q.held != HELD_THREE);
			end
		endcase
		next_char = pad ? CH_PAD : b64_symbol(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (grp_pop) begin
				busy_q <= 1'b1;
			end else if (emit && slot_q == SLOT_LAST) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				slot_q      <= slot_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_pop) begin
			grp_q <= grp_rdata;
		end
		if (emit) begin
			char_q <= next_char;
			fin_q  <= grp_q.eom && (slot_q == SLOT_LAST);
		end
	end

	assign empty        = !out_valid_q;
	assign encoded_char = char_q;
	assign final_char   = fin_q;

endmodule

/* sv/base64_stream_encoder.sv */
// top level of the base64 stream encoder
// usage:
//   input queue side: drive data_byte and end_of_message with push high; the
//   byte is taken on a rising edge with push high and full low. end_of_message
//   marks the last byte of a message and closes a partial group with padding.
//   result queue side: while empty is low, encoded_char and final_char show the
//   oldest character; it is taken on a rising edge with pop high.
//   final_char is high on the last character of a message.
// path: a closed group goes into the group queue, then into the group register
//   of the back end, and its first character then into the output register.
// throughput: one character per cycle out while results are taken; the back
//   end's character sequencer turns a group of three bytes into four; bytes
//   that only fill the group are taken one per cycle while full is low.
// stall: a group queue of GRP_DEPTH entries sits between the byte gatherer and
//   the character sequencer; while pop is low the output register holds, the
//   sequencer stops, the queue fills and then full rises.
// reset: arst_n low clears the group phase, the queue and the output register;
//   empty is high and full is low right after reset.
module base64_stream_encoder import b64e_pkg::*; #(
	parameter int unsigned GRP_DEPTH = B64E_GRP_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] encoded_char,
	output logic       final_char
);

	grp_stat_t grp_stat;
	grp_t      grp_wdata;
	grp_t      grp_rdata;
	logic      grp_push;
	logic      grp_pop;

	b64e_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.end_of_message(end_of_message),
		.grp_stat      (grp_stat),
		.grp_push      (grp_push),
		.grp_wdata     (grp_wdata)
	);

	b64e_queue #(
		.DEPTH(GRP_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (grp_push),
		.wdata (grp_wdata),
		.pop   (grp_pop),
		.rdata (grp_rdata),
		.stat  (grp_stat)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp_stat    (grp_stat),
		.grp_rdata   (grp_rdata),
		.grp_pop     (grp_pop),
		.empty       (empty),
		.pop         (pop),
		.encoded_char(encoded_char),
		.final_char  (final_char)
	);

endmodule

/* sv/b64e_checker.sv */
// port checker for the base64 stream encoder and its bind
`include "assert_macros.svh"

module b64e_checker import b64e_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] encoded_char,
	input logic       final_char
);

	logic char_ok;

	assign char_ok = (encoded_char >= CH_UPPER_A && encoded_char <= CH_UPPER_Z) ||
		(encoded_char >= CH_LOWER_A && encoded_char <= CH_LOWER_Z) ||
		(encoded_char >= CH_DIGIT_0 && encoded_char <= CH_DIGIT_9) ||
		(encoded_char == CH_PLUS) || (encoded_char == CH_SLASH) ||
		(encoded_char == CH_PAD);

	// a result that is not taken stays in place
	`ASSERT_CLK(a_hold_result, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(encoded_char) && $stable(final_char)), "result changed while stalled")

	// every character shown belongs to the base64 alphabet or is padding
	`ASSERT_CLK(a_char_alphabet, clk, arst_n, !empty |-> char_ok, "character outside alphabet")

	// no result is shown while reset is held
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> empty, "result shown during reset")

	// the group queue is clear while reset is held
	`ASSERT_ALWAYS(a_reset_not_full, clk, !arst_n |-> !full, "input blocked during reset")

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);
